/* sv/pid_controller_step_core_defines.svh */
// assertion macros for the pid controller step core checker
`ifndef PID_CONTROLLER_STEP_CORE_DEFINES_SVH
`define PID_CONTROLLER_STEP_CORE_DEFINES_SVH

// clocked assertion, quiet while reset is applied
`define PIDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PIDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pidc_pkg.sv */
// shared types, widths and codes for the pid controller step core
package pidc_pkg;

  // signal width and derived datapath widths
  localparam int DATA_WIDTH = 16;
  localparam int DT_W       = 16;
  localparam int OUT_W      = 16;
  localparam int ACC_W      = 32;
  localparam int ERR_W      = DATA_WIDTH + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int MAG_W      = ERR_W;
  localparam int DVD_W      = MAG_W + DT_W;
  localparam int REM_W      = DT_W + 1;
  localparam int CNT_W      = $clog2(DVD_W + 1);
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = (ERR_W > ACC_W) ? ERR_W : ACC_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ISUM_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 10;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 16;
  localparam int IBND_W     = 31;
  localparam int OBND_W     = 15;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BOUND = 3'd4;

  localparam logic [IBND_W-1:0] IBND_RESET = 31'd6553600;
  localparam logic [OBND_W-1:0] OBND_RESET = 15'd32767;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // multiplier operand select
  typedef enum logic [1:0] {
    MS_ERR_DT,
    MS_P,
    MS_I,
    MS_D
  } pidc_mul_sel_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [IBND_W-1:0] integral_bound;
    logic [OBND_W-1:0] output_bound;
  } pidc_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic          load;
    logic          decide;
    pidc_mul_sel_t mul_sel;
    logic          integ_en;
    logic          div_start;
    logic          div_step;
    logic          sum_en;
    logic          sum_init;
    logic          sum_shift;
    logic          out_load;
  } pidc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic div_done;
  } pidc_sts_t;

endpackage

/* sv/pidc_cfg_regs.sv */
// configuration register file for the pid controller step core
module pidc_cfg_regs import pidc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pidc_cfg_t             cfg
);

  pidc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.integral_bound <= IBND_RESET;
      cfg_r.output_bound   <= OBND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:    cfg_r.gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    cfg_r.gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    cfg_r.gain_d         <= cfg_data[GAIN_W-1:0];
        REG_INT_BOUND: cfg_r.integral_bound <= cfg_data[IBND_W-1:0];
        REG_OUT_BOUND: cfg_r.output_bound   <= cfg_data[OBND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/pidc_datapath.sv */
// datapath: error, integral, serial divider, shared multiplier and output clamp
module pidc_datapath import pidc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pidc_cmd_t                    cmd,
  output pidc_sts_t                    sts,
  input  pidc_cfg_t                    cfg,
  input  logic                         in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_target,
  input  logic signed [DATA_WIDTH-1:0] in_measured,
  input  logic [DT_W-1:0]              in_time_step,
  output logic signed [OUT_W-1:0]      out_correction,
  output logic                         out_skipped
);

  logic                     op_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     skip_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ERR_W-1:0]  prev_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [REM_W-1:0]         rem_r;
  logic [DVD_W-1:0]         dvd_r;
  logic                     neg_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [OUT_W-1:0]  corr_r;
  logic                     skipped_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  inc;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [ISUM_W-1:0]  ibnd;
  logic signed [ISUM_W-1:0]  iclamp;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  diff_abs;
  logic [REM_W-1:0]          trial;
  logic [REM_W-1:0]          dt_ext;
  logic                      q_bit;
  logic [63:0]               quo;
  logic signed [ACC_W-1:0]   deriv;
  logic signed [SUM_W-1:0]   addend;
  logic signed [SUM_W-1:0]   shf;
  logic signed [SUM_W-1:0]   obnd;
  logic signed [SUM_W-1:0]   oclamp;

  // status back to the controller
  assign sts.skip     = (op_r == OP_CLEAR) || (dt_r == '0);
  assign sts.div_done = (cnt_r == '0);

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MS_ERR_DT: begin
        mul_a = {1'b0, dt_r};
        mul_b = MUL_B_W'(err_r);
      end
      MS_P: begin
        mul_a = {1'b0, cfg.gain_p};
        mul_b = MUL_B_W'(err_r);
      end
      MS_I: begin
        mul_a = {1'b0, cfg.gain_i};
        mul_b = MUL_B_W'(acc_r);
      end
      MS_D: begin
        mul_a = {1'b0, cfg.gain_d};
        mul_b = MUL_B_W'(deriv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // integral update with floor shift and symmetric clamp
  assign inc  = prod_r >>> 8;
  assign isum = ISUM_W'(acc_r) + ISUM_W'(inc);
  assign ibnd = ISUM_W'(cfg.integral_bound);

  always_comb begin
    priority if (isum > ibnd) begin
      iclamp = ibnd;
    end else if (isum < -ibnd) begin
      iclamp = -ibnd;
    end else begin
      iclamp = isum;
    end
  end

  // error change magnitude for the divider
  assign diff     = DIFF_W'(err_r) - DIFF_W'(prev_r);
  assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

  // one restoring division step
  assign dt_ext = {1'b0, dt_r};
  assign trial  = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign q_bit  = (trial >= dt_ext);

  // signed derivative, saturated to 32 bits
  assign quo = 64'(dvd_r);

  always_comb begin
    if (!neg_r) begin
      deriv = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(quo[31:0]);
    end else begin
      deriv = (quo > 64'h8000_0000) ? -32'sh7FFF_FFFF - 32'sd1 : -signed'(quo[31:0]);
    end
  end

  // product term for the output accumulator
  assign addend = cmd.sum_shift ? (SUM_W'(prod_r) <<< 8) : SUM_W'(prod_r);

  // output floor shift and clamp
  assign shf  = sum_r >>> 16;
  assign obnd = SUM_W'(cfg.output_bound);

  always_comb begin
    priority if (shf > obnd) begin
      oclamp = obnd;
    end else if (shf < -obnd) begin
      oclamp = -obnd;
    end else begin
      oclamp = shf;
    end
  end

  // controller state that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.decide && op_r == OP_CLEAR) begin
        acc_r  <= '0;
        prev_r <= '0;
      end
      if (cmd.integ_en) begin
        acc_r <= iclamp[ACC_W-1:0];
      end
      if (cmd.div_start) begin
        prev_r <= err_r;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      dt_r  <= in_time_step;
      err_r <= ERR_W'(in_target) - ERR_W'(in_measured);
    end
    if (cmd.decide) begin
      skip_r <= sts.skip;
    end
    prod_r <= prod_nxt;
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= {diff_abs[MAG_W-1:0], {DT_W{1'b0}}};
      neg_r <= diff[DIFF_W-1];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? (trial - dt_ext) : trial;
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
    end
    if (cmd.sum_en) begin
      sum_r <= (cmd.sum_init ? '0 : sum_r) + addend;
    end
    if (cmd.out_load) begin
      corr_r    <= skip_r ? '0 : oclamp[OUT_W-1:0];
      skipped_r <= skip_r;
    end
  end

  assign out_correction = corr_r;
  assign out_skipped    = skipped_r;

endmodule

/* sv/pidc_ctrl.sv */
// sequencing state machine for the pid controller step core
module pidc_ctrl import pidc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pidc_sts_t sts,
  output pidc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_E,
    ST_INTEG,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   can_load;

  assign accept   = in_valid && !in_stall_r;
  assign can_load = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MS_ERR_DT;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.skip ? ST_DONE : ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.mul_sel = MS_ERR_DT;
        state_nxt   = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ_en  = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_MUL_P;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_MUL_P: begin
        cmd.mul_sel = MS_P;
        state_nxt   = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_sel   = MS_I;
        cmd.sum_en    = 1'b1;
        cmd.sum_init  = 1'b1;
        cmd.sum_shift = 1'b1;
        state_nxt     = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_sel = MS_D;
        cmd.sum_en  = 1'b1;
        state_nxt   = ST_ACC_D;
      end
      ST_ACC_D: begin
        cmd.sum_en    = 1'b1;
        cmd.sum_shift = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (can_load) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered handshake outputs, input held off during reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != ST_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

/* sv/pid_controller_step_core.sv */
// top level of the fixed-point pid controller step core
// Usage:
//   Input channel (in_valid / in_stall) carries one request: opcode, target,
//   measured and time_step. Output channel (out_valid / out_stall) returns
//   one result per request: correction (Q8.8) and skipped.
//   Gains and bounds are written through cfg_valid / cfg_ready / cfg_index /
//   cfg_data while the core is idle; cfg_ready is always high.
// Sequencing:
//   A clear or zero time step request goes from decode straight to loading
//   the result. A compute request passes setup (decode, error times time
//   step, integral update), the one-bit-per-cycle restoring divider of the
//   derivative, the gain products through the shared 17x32 multiplier and
//   the load. One request is worked at a time; in_stall drops at the edge
//   that loads the result, and the load waits while out_stall holds a result.
// Reset:
//   Synchronous active-low rst_n zeroes the integral and last error, loads
//   the reset gains and bounds, empties the output register and keeps
//   in_stall high until the cycle after reset is released.
// Stall:
//   While out_stall holds a result, the core may finish the next request
module pid_controller_step_core import pidc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_target,
  input  logic signed [DATA_WIDTH-1:0] in_measured,
  input  logic [DT_W-1:0]              in_time_step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      out_correction,
  output logic                         out_skipped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // the held result then waits until the output register frees

  pidc_cfg_t cfg;
  pidc_cmd_t cmd;
  pidc_sts_t sts;

  // configuration registers
  pidc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic
  pidc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .in_opcode      (in_opcode),
    .in_target      (in_target),
    .in_measured    (in_measured),
    .in_time_step   (in_time_step),
    .out_correction (out_correction),
    .out_skipped    (out_skipped)
  );

endmodule

/* sv/pidc_checker.sv */
// port-level checker for the pid controller step core, with its bind
`include "pid_controller_step_core_defines.svh"

module pidc_checker import pidc_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [OUT_W-1:0]      out_correction,
  input logic                         out_skipped
);

  // a skipped result never carries a correction
  `PIDC_ASSERT(a_skip_zero, out_valid && out_skipped |-> out_correction == '0, "skipped with correction")

  // an accepted request blocks the input on the next cycle
  `PIDC_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input open after accept")

  // a stalled result holds
  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_correction) && $stable(out_skipped);
  endproperty
  `PIDC_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

  // no result straight out of reset
  `PIDC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind pid_controller_step_core pidc_checker u_pidc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_correction (out_correction),
  .out_skipped    (out_skipped)
);

/* tb/pid_controller_step_core_tb.sv */
// self-checking testbench for the pid controller step core
`timescale 1ns / 1ps

class pid_step_scoreboard;
  // controller settings and state mirrored from the core
  longint gain_p, gain_i, gain_d, int_bound, out_bound;
  longint integ_acc, last_err;
  logic signed [15:0] want_corr[$];
  logic               want_skip[$];
  int errors;
  int results_seen;

  function new();
    gain_p = 0; gain_i = 0; gain_d = 0;
    int_bound = 6553600; out_bound = 32767;
    integ_acc = 0; last_err = 0;
    errors = 0; results_seen = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      pidc_pkg::REG_GAIN_P:    gain_p = val[15:0];
      pidc_pkg::REG_GAIN_I:    gain_i = val[15:0];
      pidc_pkg::REG_GAIN_D:    gain_d = val[15:0];
      pidc_pkg::REG_INT_BOUND: int_bound = val[30:0];
      pidc_pkg::REG_OUT_BOUND: out_bound = val[14:0];
      default: ;
    endcase
  endfunction

  // floor division by 2^k
  function longint floor_shr(longint x, int k);
    return x >>> k;
  endfunction

  function longint clamp(longint x, longint b);
    if (x > b) return b;
    if (x < -b) return -b;
    return x;
  endfunction

  // note an accepted request and predict its result
  function void note_request(logic op, logic signed [15:0] tgt,
                             logic signed [15:0] meas, logic [15:0] dt);
    longint err, deriv, sum, res;
    if (op == pidc_pkg::OP_CLEAR) begin
      integ_acc = 0; last_err = 0;
      want_corr.push_back('0); want_skip.push_back(1'b1);
      return;
    end
    if (dt == 0) begin
      want_corr.push_back('0); want_skip.push_back(1'b1);
      return;
    end
    err = longint'(tgt) - longint'(meas);
    integ_acc = clamp(integ_acc + floor_shr(err * longint'(dt), 8), int_bound);
    deriv = ((err - last_err) * 65536) / longint'(dt);
    if (deriv > 64'sd2147483647) deriv = 64'sd2147483647;
    if (deriv < -64'sd2147483648) deriv = -64'sd2147483648;
    last_err = err;
    sum = gain_p * err * 256 + gain_i * integ_acc + gain_d * deriv * 256;
    res = clamp(floor_shr(sum, 16), out_bound);
    want_corr.push_back(res[15:0]);
    want_skip.push_back(1'b0);
  endfunction

  function void report(string what);
    errors++;
    $display("error: %s", what);
  endfunction

  // compare one result with the oldest prediction
  function void check_result(logic signed [15:0] corr, logic skip);
    logic signed [15:0] wc;
    logic ws;
    results_seen++;
    if (want_corr.size() == 0) begin
      report($sformatf("unexpected result corr=%0d skip=%0b", corr, skip));
      return;
    end
    wc = want_corr.pop_front();
    ws = want_skip.pop_front();
    if (corr !== wc)
      report($sformatf("correction got %0d want %0d", corr, wc));
    if (skip !== ws)
      report($sformatf("skipped got %0b want %0b", skip, ws));
  endfunction
endclass

module pid_controller_step_core_tb;
  import pidc_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_opcode = 0;
  logic signed [15:0] in_target = 0, in_measured = 0;
  logic [15:0] in_time_step = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_correction;
  logic out_skipped;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_sent = 0;
  pid_step_scoreboard sb = new();

  pid_controller_step_core dut (.*);

  always #2 clk = ~clk;

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_correction, out_skipped);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // send one request, waiting for acceptance; valid stays up for the next one
  task automatic send_request(logic op, logic [15:0] tgt, logic [15:0] meas,
                              logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_target <= tgt;
    in_measured <= meas;
    in_time_step <= dt;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, tgt, meas, dt);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.want_corr.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                         logic [31:0] ib, logic [31:0] ob);
    write_reg(REG_GAIN_P, 32'(p));
    write_reg(REG_GAIN_I, 32'(i));
    write_reg(REG_GAIN_D, 32'(d));
    write_reg(REG_INT_BOUND, ib);
    write_reg(REG_OUT_BOUND, ob);
  endtask

  // random request, mostly modest steps with occasional extremes
  task automatic random_request();
    logic [15:0] dt, tgt, meas;
    logic op;
    op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_STEP;
    case ($urandom_range(5))
      0: dt = 0;
      1: dt = 16'($urandom_range(1, 4));
      2: dt = 16'hffff - 16'($urandom_range(3));
      default: dt = 16'($urandom);
    endcase
    if ($urandom_range(3) == 0) begin
      tgt = 16'($urandom); meas = 16'($urandom);
    end else begin
      tgt = 16'($urandom_range(0, 4095)) - 16'd2048;
      meas = tgt + 16'($urandom_range(0, 511)) - 16'd256;
    end
    send_request(op, tgt, meas, dt);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings then extremes
    send_request(OP_STEP, 16'sd256, 16'sd0, 16'd655);
    drain();
    set_all(16'h0100, 16'h0080, 16'h0010, 32'd6553600, 32'd32767);
    send_request(OP_STEP, 16'h7fff, 16'h8000, 16'hffff);
    send_request(OP_STEP, 16'h8000, 16'h7fff, 16'hffff);
    send_request(OP_STEP, 16'h8000, 16'h7fff, 16'd1);
    send_request(OP_STEP, 16'h7fff, 16'h8000, 16'd1);
    send_request(OP_STEP, 16'sd100, 16'sd50, 16'd0);
    send_request(OP_CLEAR, 16'h1234, 16'h4321, 16'd77);
    send_request(OP_STEP, 16'sd0, 16'sd0, 16'd1000);
    send_request(OP_STEP, -16'sd5, 16'sd3, 16'd3);
    send_request(OP_STEP, 16'sd0, 16'sd1, 16'd65535);
    drain();
    set_all(16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff);
    send_request(OP_STEP, 16'h7fff, 16'h8000, 16'd1);
    send_request(OP_STEP, 16'h8000, 16'h7fff, 16'd1);
    send_request(OP_STEP, 16'sd1, 16'sd0, 16'd2);
    send_request(OP_CLEAR, 16'h0, 16'h0, 16'd0);
    drain();
    set_all(16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    send_request(OP_STEP, 16'h7fff, 16'h8000, 16'd9);
    send_request(OP_STEP, 16'h1000, 16'h0000, 16'd1);
    drain();

    // random phases across idle patterns and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 4)
        set_all(16'h0200, 16'h0040, 16'h0004, 32'd655360, 32'd8000);
      else
        set_all(16'($urandom), 16'($urandom_range(0, 1024)),
                16'($urandom_range(0, 256)), $urandom, $urandom);
      for (int n = 0; n < 160; n++) begin
        random_request();
        if (n == 80) drain();
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    $display("covered %0d requests over 8 random phases with varied gains, bounds",
             requests_sent);
    $display("and idle patterns; %0d results checked", sb.results_seen);
    if (sb.errors == 0 && sb.want_corr.size() == 0)
      $display("pid_controller_step_core: match");
    else
      $display("pid_controller_step_core: mismatch");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #20ms;
    $display("pid_controller_step_core: mismatch");
    $finish;
  end
endmodule

/* pid_controller_step_core.f */
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_cfg_regs.sv
sv/pidc_datapath.sv
sv/pidc_ctrl.sv
sv/pid_controller_step_core.sv
sv/pidc_checker.sv
tb/pid_controller_step_core_tb.sv
